### src/prs_pkg.sv
// shared types, constants and codes of the projection profile run segmenter
package prs_pkg;

  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int MAX_LANES = 4096;
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int CNT_LIM   = (MAX_LANES < CNT_MAX) ? MAX_LANES : CNT_MAX;

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  localparam int DIV_STEPS = CNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LANE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_AT_END = CFG_IDX_W'(1);

  // one queued operation: a run record or a summary request
  typedef struct packed {
    logic             is_summary;
    logic [IDX_W-1:0] run_first;
    logic [IDX_W-1:0] run_last;
    logic [CNT_W-1:0] run_count;
    logic [CNT_W-1:0] gap_total;
    logic             last;
  } op_t;

  typedef struct packed {
    logic push0;
    logic push1;
    op_t  op0;
    op_t  op1;
  } opq_push_t;

  typedef struct packed {
    logic empty;
    logic room2;
  } opq_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

### src/prs_if.sv
// channel interfaces: pixel input, result output, configuration write
interface prs_pixel_if;
  logic valid;
  logic ready;
  logic pixel_dark;
  logic lane_end;
  logic region_end;
  modport source (output valid, pixel_dark, lane_end, region_end, input ready);
  modport sink   (input valid, pixel_dark, lane_end, region_end, output ready);
endinterface

interface prs_result_if;
  logic                       valid;
  logic                       ready;
  logic                       is_summary;
  logic [prs_pkg::IDX_W-1:0]  run_first;
  logic [prs_pkg::IDX_W-1:0]  run_last;
  logic [prs_pkg::CNT_W-1:0]  run_count;
  logic [prs_pkg::IDX_W-1:0]  average_gap;
  logic                       last;
  modport source (output valid, is_summary, run_first, run_last, run_count, average_gap, last,
                  input ready);
  modport sink   (input valid, is_summary, run_first, run_last, run_count, average_gap, last,
                  output ready);
endinterface

interface prs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [prs_pkg::CFG_IDX_W-1:0]   index;
  logic [prs_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/prs_front.sv
// front: accepts pixels, tracks lanes and runs, queues run and summary operations
module prs_front (
  input  logic                clk,
  input  logic                rst_n,
  prs_pixel_if.sink           in_ch,
  prs_cfg_if.sink             cfg_ch,
  input  prs_pkg::opq_stat_t  q_stat,
  output prs_pkg::opq_push_t  q_push
);

  logic [prs_pkg::IDX_W-1:0] first_lane_r;
  logic                      close_r;

  logic [prs_pkg::IDX_W-1:0] lane_index_r, lane_index_nxt;
  logic                      lane_ink_r, lane_ink_nxt;
  logic                      in_run_r, in_run_nxt;
  logic [prs_pkg::IDX_W-1:0] run_start_r, run_start_nxt;
  logic [prs_pkg::IDX_W-1:0] prev_last_r, prev_last_nxt;
  logic [prs_pkg::CNT_W-1:0] runs_r, runs_nxt;
  logic [prs_pkg::CNT_W-1:0] gap_total_r, gap_total_nxt;
  logic                      busy_r, busy_nxt;

  logic                      accept;
  logic                      ink;
  logic [prs_pkg::IDX_W-1:0] gap;
  logic [prs_pkg::CNT_W:0]   gap_sum;
  logic                      run_out;
  logic [prs_pkg::IDX_W-1:0] run_out_first;

  assign in_ch.ready  = q_stat.room2;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && q_stat.room2;

  assign ink     = lane_ink_r | in_ch.pixel_dark;
  assign gap     = lane_index_r - prev_last_r;
  assign gap_sum = {1'b0, gap_total_r} + (prs_pkg::CNT_W + 1)'(gap);

  always_comb begin
    lane_index_nxt = lane_index_r;
    lane_ink_nxt   = ink;
    in_run_nxt     = in_run_r;
    run_start_nxt  = run_start_r;
    prev_last_nxt  = prev_last_r;
    runs_nxt       = runs_r;
    gap_total_nxt  = gap_total_r;
    busy_nxt       = 1'b1;
    run_out        = 1'b0;
    run_out_first  = run_start_r;
    q_push         = '0;

    if (in_ch.lane_end || in_ch.region_end) begin
      if (ink) begin
        if (!in_run_r) begin
          in_run_nxt    = 1'b1;
          run_start_nxt = lane_index_r;
          if (runs_r != '0) begin
            gap_total_nxt = gap_sum[prs_pkg::CNT_W] ? prs_pkg::CNT_W'(prs_pkg::CNT_MAX)
                                                    : gap_sum[prs_pkg::CNT_W-1:0];
          end
        end
      end else if (in_run_r) begin
        in_run_nxt    = 1'b0;
        run_out       = 1'b1;
        prev_last_nxt = lane_index_r;
        if (runs_r < prs_pkg::CNT_W'(prs_pkg::CNT_LIM)) runs_nxt = runs_r + 1'b1;
      end
      lane_ink_nxt = 1'b0;

      if (in_ch.region_end) begin
        // close a run still open at the final lane when close_at_end is set
        if (in_run_nxt && close_r) begin
          run_out       = 1'b1;
          run_out_first = run_start_nxt;
          if (runs_nxt < prs_pkg::CNT_W'(prs_pkg::CNT_LIM)) runs_nxt = runs_nxt + 1'b1;
        end
      end else begin
        lane_index_nxt = lane_index_r + 1'b1;
      end
    end

    // queue entries: run record first, summary after it
    if (run_out) begin
      q_push.push0            = accept;
      q_push.op0.is_summary   = 1'b0;
      q_push.op0.run_first    = run_out_first;
      q_push.op0.run_last     = lane_index_r;
      q_push.op0.last         = !in_ch.region_end;
    end
    if (in_ch.region_end) begin
      if (run_out) begin
        q_push.push1           = accept;
        q_push.op1.is_summary  = 1'b1;
        q_push.op1.run_count   = runs_nxt;
        q_push.op1.gap_total   = gap_total_nxt;
        q_push.op1.last        = 1'b1;
      end else begin
        q_push.push0           = accept;
        q_push.op0.is_summary  = 1'b1;
        q_push.op0.run_count   = runs_nxt;
        q_push.op0.gap_total   = gap_total_nxt;
        q_push.op0.last        = 1'b1;
      end
      // region state clears for the next region
      lane_index_nxt = first_lane_r;
      in_run_nxt     = 1'b0;
      run_start_nxt  = '0;
      prev_last_nxt  = '0;
      runs_nxt       = '0;
      gap_total_nxt  = '0;
      busy_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_lane_r <= '0;
      close_r      <= 1'b1;
      lane_index_r <= '0;
      lane_ink_r   <= 1'b0;
      in_run_r     <= 1'b0;
      run_start_r  <= '0;
      prev_last_r  <= '0;
      runs_r       <= '0;
      gap_total_r  <= '0;
      busy_r       <= 1'b0;
    end else begin
      // start lane reloads at once while no pixel of the region has arrived
      if (cfg_ch.valid && (cfg_ch.index == prs_pkg::CFG_FIRST_LANE) && !busy_r) begin
        lane_index_r <= cfg_ch.data[prs_pkg::IDX_W-1:0];
      end else if (accept) begin
        lane_index_r <= lane_index_nxt;
      end
      if (accept) begin
        lane_ink_r   <= lane_ink_nxt;
        in_run_r     <= in_run_nxt;
        run_start_r  <= run_start_nxt;
        prev_last_r  <= prev_last_nxt;
        runs_r       <= runs_nxt;
        gap_total_r  <= gap_total_nxt;
        busy_r       <= busy_nxt;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          prs_pkg::CFG_FIRST_LANE:   first_lane_r <= cfg_ch.data[prs_pkg::IDX_W-1:0];
          prs_pkg::CFG_CLOSE_AT_END: close_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### src/prs_op_fifo.sv
// operation queue between front and back, up to two pushes and one pop a cycle
module prs_op_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  prs_pkg::opq_push_t  q_push,
  output prs_pkg::opq_stat_t  q_stat,
  input  logic                pop,
  output prs_pkg::op_t        head
);

  prs_pkg::op_t                  mem_r [prs_pkg::OPQ_DEPTH];
  logic [prs_pkg::OPQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [prs_pkg::OPQ_CNT_W-1:0] count_r;
  logic [prs_pkg::OPQ_PTR_W-1:0] wr_ptr1;
  logic [prs_pkg::OPQ_CNT_W-1:0] n_push;

  assign wr_ptr1 = wr_ptr_r + 1'b1;
  assign n_push  = prs_pkg::OPQ_CNT_W'(q_push.push0) + prs_pkg::OPQ_CNT_W'(q_push.push1);

  assign q_stat.empty = (count_r == '0);
  assign q_stat.room2 = (count_r <= prs_pkg::OPQ_CNT_W'(prs_pkg::OPQ_DEPTH - 2));
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (q_push.push0) mem_r[wr_ptr_r] <= q_push.op0;
    if (q_push.push1) mem_r[wr_ptr1]  <= q_push.op1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + prs_pkg::OPQ_PTR_W'(n_push);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + n_push - prs_pkg::OPQ_CNT_W'(pop);
    end
  end

endmodule

### src/prs_back.sv
// back: turns queued operations into result items, with a serial divider for the average gap
module prs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  prs_pkg::opq_stat_t  q_stat,
  input  prs_pkg::op_t        head,
  output logic                pop,
  prs_result_if.source        out_ch
);

  prs_pkg::back_state_t state_r, state_nxt;

  prs_pkg::op_t                  hold_r;
  logic [prs_pkg::IDX_W-1:0]     avg_r;
  logic [prs_pkg::CNT_W-1:0]     rem_r, quo_r, div_r;
  logic [prs_pkg::DIV_CNT_W-1:0] step_r;

  logic                          need_div;
  logic                          div_done;
  logic [prs_pkg::CNT_W:0]       trial;
  logic                          fits;
  logic [prs_pkg::CNT_W-1:0]     rem_step;
  logic [prs_pkg::CNT_W-1:0]     quo_step;

  assign need_div = head.is_summary && (head.run_count > prs_pkg::CNT_W'(1));
  assign div_done = (step_r == prs_pkg::DIV_CNT_W'(prs_pkg::DIV_STEPS - 1));

  // restoring division, one quotient bit a cycle
  assign trial    = {rem_r, quo_r[prs_pkg::CNT_W-1]};
  assign fits     = (trial >= {1'b0, div_r});
  assign rem_step = fits ? prs_pkg::CNT_W'(trial - {1'b0, div_r}) : trial[prs_pkg::CNT_W-1:0];
  assign quo_step = {quo_r[prs_pkg::CNT_W-2:0], fits};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prs_pkg::BK_IDLE: if (!q_stat.empty) state_nxt = need_div ? prs_pkg::BK_DIV
                                                               : prs_pkg::BK_OUT;
      prs_pkg::BK_DIV:  if (div_done) state_nxt = prs_pkg::BK_OUT;
      prs_pkg::BK_OUT:  if (out_ch.ready) state_nxt = prs_pkg::BK_IDLE;
      default:          state_nxt = prs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state_r)
      prs_pkg::BK_IDLE: pop = !q_stat.empty;
      prs_pkg::BK_OUT:  out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_ch.is_summary  = hold_r.is_summary;
  assign out_ch.run_first   = hold_r.is_summary ? '0 : hold_r.run_first;
  assign out_ch.run_last    = hold_r.is_summary ? '0 : hold_r.run_last;
  assign out_ch.run_count   = hold_r.is_summary ? hold_r.run_count : '0;
  assign out_ch.average_gap = hold_r.is_summary ? avg_r : '0;
  assign out_ch.last        = hold_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= prs_pkg::BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold_r <= head;
      avg_r  <= '0;
      rem_r  <= '0;
      quo_r  <= head.gap_total;
      div_r  <= head.run_count;
      step_r <= '0;
    end else if (state_r == prs_pkg::BK_DIV) begin
      rem_r  <= rem_step;
      quo_r  <= quo_step;
      step_r <= step_r + 1'b1;
      if (div_done) avg_r <= quo_step[prs_pkg::IDX_W-1:0];
    end
  end

endmodule

### src/projection_profile_run_segmenter.sv
// top level of the projection profile run segmenter
//
//  channel  dir  handshake        item
//  in_ch    in   valid/ready      pixel_dark, lane_end, region_end
//  out_ch   out  valid/ready      is_summary, run_first, run_last, run_count, average_gap, last
//  cfg_ch   in   valid/ready      index (0 first_lane_index, 1 close_at_end), data
//
// pixels are taken one per cycle while the operation queue has room for two entries
// a run record is written into the operation queue and popped into the back end's hold
// register before out_ch offers it; each result item holds the back end through its idle
// and output states, and a summary with two or more runs also passes the bit-serial divide state
// out_ch stalls back up through the four-entry queue to in_ch; cfg_ch is always ready
// rst_n is synchronous active low and clears control state; no clearing pass is needed
module projection_profile_run_segmenter (
  input  logic     clk,
  input  logic     rst_n,
  prs_pixel_if.sink    in_ch,
  prs_result_if.source out_ch,
  prs_cfg_if.sink      cfg_ch
);

  // queue traffic between the front and back ends
  prs_pkg::opq_push_t q_push;
  prs_pkg::opq_stat_t q_stat;
  prs_pkg::op_t       head;
  logic               pop;

  // lane and run tracking, configuration registers
  prs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_stat (q_stat),
    .q_push (q_push)
  );

  // decouples pixel intake from result delivery and division
  prs_op_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_stat (q_stat),
    .pop    (pop),
    .head   (head)
  );

  // result formatting and average gap division
  prs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
